FILE: rtl/color_temperature_ir_compensated_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the color temperature pipeline
// each macro expects clk and rst in the scope where it is used
// ---------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_IR_COMPENSATED_TOP_ASSERT_SVH
`define COLOR_TEMPERATURE_IR_COMPENSATED_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that holds at every clock edge outside reset
`define CTIR_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CTIR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CTIR_ASSERT_ALWAYS(name, expr, msg)

`define CTIR_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: rtl/ctir_pkg.sv
// ---------------------------------------------------------------------------
// ctir_pkg
// shared types and constants of the color temperature pipeline
// ---------------------------------------------------------------------------
package ctir_pkg;

  localparam int CHAN_W             = 16;
  localparam int SUM_W              = 18;
  localparam int NUM_W              = 28;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = NUM_W / DIV_BITS_PER_STAGE;

  localparam logic [7:0]  SETTING_RESET   = 8'd255;
  localparam logic [8:0]  SPAN_BASE       = 9'd256;
  localparam logic [8:0]  SPAN_ANALOG_MAX = 9'd63;
  localparam logic [15:0] SAT_DIGITAL     = 16'hFFFF;
  // 1024 counts per step less a quarter
  localparam logic [15:0] LEVEL_PER_SPAN  = 16'd768;
  localparam logic [11:0] CCT_COEF        = 12'd3810;
  localparam logic [15:0] CCT_OFFSET      = 16'd1391;

  // control that travels with each word; blank forces a zero result
  typedef struct packed {
    logic valid;
    logic blank;
  } ctir_ctl_t;

endpackage

FILE: rtl/ctir_div.sv
// ---------------------------------------------------------------------------
// ctir_div
// pipelined restoring divider, two quotient bits per register stage
// ---------------------------------------------------------------------------
`include "color_temperature_ir_compensated_top_assert.svh"

module ctir_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  ctir_pkg::ctir_ctl_t       in_ctl,
  input  logic [ctir_pkg::NUM_W-1:0]  in_num,
  input  logic [ctir_pkg::CHAN_W-1:0] in_div,
  output ctir_pkg::ctir_ctl_t       out_ctl,
  output logic [ctir_pkg::NUM_W-1:0]  out_quo
);
  import ctir_pkg::*;

  ctir_ctl_t         ctl_q [DIV_STAGES];
  logic [CHAN_W-1:0] rem_q [DIV_STAGES];
  logic [NUM_W-1:0]  dq_q  [DIV_STAGES];
  logic [CHAN_W-1:0] dv_q  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_vec;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    ctir_ctl_t         src_ctl;
    logic [CHAN_W-1:0] src_rem;
    logic [NUM_W-1:0]  src_dq;
    logic [CHAN_W-1:0] src_dv;
    logic [CHAN_W-1:0] rem_next;
    logic [NUM_W-1:0]  dq_next;

    if (s == 0) begin : g_first
      assign src_ctl = in_ctl;
      assign src_rem = '0;
      assign src_dq  = in_num;
      assign src_dv  = in_div;
    end else begin : g_rest
      assign src_ctl = ctl_q[s-1];
      assign src_rem = rem_q[s-1];
      assign src_dq  = dq_q[s-1];
      assign src_dv  = dv_q[s-1];
    end

    // dq shifts dividend bits out the top and quotient bits in the bottom
    always_comb begin
      logic [CHAN_W:0] trial;
      rem_next = src_rem;
      dq_next  = src_dq;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        trial   = {rem_next, dq_next[NUM_W-1]};
        dq_next = {dq_next[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, src_dv}) begin
          rem_next   = CHAN_W'(trial - {1'b0, src_dv});
          dq_next[0] = 1'b1;
        end else begin
          rem_next = trial[CHAN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s] <= '0;
      end else if (en) begin
        ctl_q[s] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_next;
        dq_q[s]  <= dq_next;
        dv_q[s]  <= src_dv;
      end
    end

    assign vld_vec[s] = ctl_q[s].valid;

    `CTIR_ASSERT_ALWAYS(a_rem_below_div, !(ctl_q[s].valid && !ctl_q[s].blank) || (rem_q[s] < dv_q[s]), "partial remainder not below divisor")
  end

  assign out_ctl = ctl_q[DIV_STAGES-1];
  assign out_quo = dq_q[DIV_STAGES-1];

  `CTIR_ASSERT_NEXT(a_div_stall_holds, !en, $stable(vld_vec), "divider valid bits moved during stall")
  `CTIR_ASSERT_ALWAYS(a_div_nonzero, !(out_ctl.valid && !out_ctl.blank) || (dv_q[DIV_STAGES-1] != '0), "non-blank word with zero divisor")

endmodule

FILE: rtl/color_temperature_ir_compensated_top.sv
// ---------------------------------------------------------------------------
// color_temperature_ir_compensated_top
// color temperature in kelvin from one rgbc sample, infrared part removed
//
//   channel   direction  fields (low bit first)
//   s_axis    in         red_count, green_count, blue_count, clear_count
//   m_axis    out        kelvin
//   cfg       in         integration_setting
//
// one word per cycle unless the output register stalls; four front stages (sum,
// infrared, correction, coefficient multiply), the 14-stage divider that resolves
// two quotient bits per stage, and the output register.
// reset clears every valid bit and loads integration_setting with 255.
// a word waiting in the output register stalls the whole pipeline;
// s_axis_tready follows that stall, nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "color_temperature_ir_compensated_top_assert.svh"

module color_temperature_ir_compensated_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // red_count, green_count, blue_count, clear_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // kelvin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data       // integration_setting
);
  import ctir_pkg::*;

  logic [7:0] integration_setting;
  logic       en;

  // input decode and saturation level
  logic [CHAN_W-1:0] red_in, green_in, blue_in, clear_in;
  logic [8:0]        span;
  logic [15:0]       sat_level;
  logic              blank_in;
  logic [SUM_W-1:0]  sum_in;

  // stage 1
  ctir_ctl_t         ctl1;
  logic [CHAN_W-1:0] red1, blue1, clear1;
  logic [SUM_W-1:0]  sum1;

  // stage 2
  ctir_ctl_t         ctl2;
  logic [CHAN_W-1:0] red2, blue2, ir2;
  logic [SUM_W-1:0]  excess;
  logic [CHAN_W-1:0] ir_next;

  // stage 3
  ctir_ctl_t         ctl3;
  logic [CHAN_W-1:0] red3, blue3;
  logic [CHAN_W-1:0] red3_next, blue3_next;

  // stage 4
  ctir_ctl_t         ctl4;
  logic [NUM_W-1:0]  num4;
  logic [CHAN_W-1:0] div4;

  // divider and output
  ctir_ctl_t         div_ctl;
  logic [NUM_W-1:0]  div_quo;
  logic              out_vld;
  logic [15:0]       kelvin;
  logic [3:0]        vld_vec;

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign cfg_ready     = !rst;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = kelvin;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_setting <= SETTING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      integration_setting <= cfg_data;
    end
  end

  assign red_in   = s_axis_tdata[15:0];
  assign green_in = s_axis_tdata[31:16];
  assign blue_in  = s_axis_tdata[47:32];
  assign clear_in = s_axis_tdata[63:48];

  // span runs 1..256; short spans saturate at 3/4 of full analog range
  assign span      = SPAN_BASE - {1'b0, integration_setting};
  assign sat_level = (span > SPAN_ANALOG_MAX) ? SAT_DIGITAL
                   : {10'd0, span[5:0]} * LEVEL_PER_SPAN;
  assign blank_in  = (clear_in == '0) || (clear_in >= sat_level);
  assign sum_in    = {2'd0, red_in} + {2'd0, green_in} + {2'd0, blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
    end else if (en) begin
      ctl1 <= '{valid: s_axis_tvalid, blank: blank_in};
      ctl2 <= ctl1;
      ctl3 <= '{valid: ctl2.valid, blank: ctl2.blank || (red3_next == '0)};
      ctl4 <= ctl3;
    end
  end

  // inferred infrared: half of what rgb exceeds clear by
  assign excess     = sum1 - {2'd0, clear1};
  assign ir_next    = (sum1 > {2'd0, clear1}) ? excess[CHAN_W:1] : '0;
  assign red3_next  = red2 - ir2;
  assign blue3_next = blue2 - ir2;

  always_ff @(posedge clk) begin
    if (en) begin
      red1   <= red_in;
      blue1  <= blue_in;
      clear1 <= clear_in;
      sum1   <= sum_in;
      red2   <= red1;
      blue2  <= blue1;
      ir2    <= ir_next;
      red3   <= red3_next;
      blue3  <= blue3_next;
      num4   <= {12'd0, blue3} * {16'd0, CCT_COEF};
      div4   <= red3;
    end
  end

  ctir_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (ctl4),
    .in_num  (num4),
    .in_div  (div4),
    .out_ctl (div_ctl),
    .out_quo (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kelvin <= div_ctl.blank ? '0 : div_quo[15:0] + CCT_OFFSET;
    end
  end

  assign vld_vec = {ctl1.valid, ctl2.valid, ctl3.valid, ctl4.valid};

  `CTIR_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, ctl1.valid, "accepted word missing from first stage")
  `CTIR_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_vec) && out_vld, "front valid bits moved during stall")
  `CTIR_ASSERT_ALWAYS(a_clear_zero_blank, !(ctl1.valid && clear1 == '0) || ctl1.blank, "zero clear count not blanked")

endmodule
